@@ rtl/core/lrt_pkg.sv @@
`timescale 1ns / 1ps
package lrt_pkg;

   localparam int FRAME_W     = 6;
   localparam int NUM_FRAMES  = 2 ** FRAME_W;
   localparam int COUNT_W     = $clog2(NUM_FRAMES + 1);
   localparam int ACTION_W    = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_VICTIM = 2'd0,
      ACT_PIN    = 2'd1,
      ACT_UNPIN  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      OP_VICTIM,
      OP_PIN,
      OP_UNPIN,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [FRAME_W-1:0] frame;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

   typedef enum logic {
      BK_IDLE,
      BK_DETACH
   } back_state_type;

endpackage

@@ rtl/core/lrt_front.sv @@
`timescale 1ns / 1ps
module lrt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lrt_pkg::ACTION_W-1:0]  req_action,
   input  logic [lrt_pkg::FRAME_W-1:0]   req_frame_number,
   output lrt_pkg::cmd_slot_type         push,
   input  logic                          push_ready
);
   import lrt_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   op_type  op_dec;
   logic    load_en;

   // unused action codes become a no-op that still yields one item
   always_comb begin
      unique case (req_action)
         ACT_VICTIM: op_dec = OP_VICTIM;
         ACT_PIN:    op_dec = OP_PIN;
         ACT_UNPIN:  op_dec = OP_UNPIN;
         default:    op_dec = OP_NOP;
      endcase
   end

   assign load_en = !valid_ff || push_ready;
   assign busy    = !load_en;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (load_en) begin
         valid_in     = start;
         cmd_in.op    = op_dec;
         cmd_in.frame = req_frame_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign push.valid = valid_ff;
   assign push.cmd   = cmd_ff;

endmodule

@@ rtl/core/lrt_queue.sv @@
`timescale 1ns / 1ps
module lrt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  lrt_pkg::cmd_slot_type push,
   output logic                  push_ready,
   input  logic                  pop,
   output lrt_pkg::cmd_slot_type head
);
   import lrt_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCOUNT_W'(QUEUE_DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

@@ rtl/core/lrt_back.sv @@
`timescale 1ns / 1ps
module lrt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  lrt_pkg::cmd_slot_type        head,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic                         rsp_victim_found,
   output logic [lrt_pkg::FRAME_W-1:0]  rsp_victim_frame,
   output logic [lrt_pkg::COUNT_W-1:0]  rsp_candidate_count
);
   import lrt_pkg::*;

   back_state_type       state_ff, state_in;
   logic [NUM_FRAMES-1:0] member_ff, member_in;
   logic [FRAME_W-1:0]   oldest_ff, oldest_in;
   logic [FRAME_W-1:0]   newest_ff, newest_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [FRAME_W-1:0]   tgt_ff, tgt_in;
   logic                 is_victim_ff, is_victim_in;

   logic [FRAME_W-1:0]   next_mem [NUM_FRAMES];
   logic [FRAME_W-1:0]   prev_mem [NUM_FRAMES];
   logic [FRAME_W-1:0]   nx_rd_ff, pv_rd_ff;
   logic                 next_we, prev_we;
   logic [FRAME_W-1:0]   next_waddr, next_wdata, prev_waddr, prev_wdata;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff, found_in;
   logic [FRAME_W-1:0]   victim_ff, victim_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [FRAME_W-1:0]   tgt;
   logic                 is_member, detach_go, append_go, multi;

   // victim requests act on the oldest frame
   assign tgt       = (head.cmd.op == OP_VICTIM) ? oldest_ff : head.cmd.frame;
   assign is_member = member_ff[tgt];
   assign detach_go = head.valid && (((head.cmd.op == OP_VICTIM) && (count_ff != '0)) ||
                                     ((head.cmd.op == OP_PIN) && is_member));
   assign append_go = head.valid && (head.cmd.op == OP_UNPIN) && !is_member;
   assign multi     = (count_ff > COUNT_W'(1));

   always_comb begin
      unique case (state_ff)
         BK_IDLE:   state_in = (detach_go && multi) ? BK_DETACH : BK_IDLE;
         BK_DETACH: state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      member_in    = member_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      count_in     = count_ff;
      tgt_in       = tgt_ff;
      is_victim_in = is_victim_ff;
      next_we      = 1'b0;
      next_waddr   = newest_ff;
      next_wdata   = tgt;
      prev_we      = 1'b0;
      prev_waddr   = tgt;
      prev_wdata   = newest_ff;
      rsp_valid_in = 1'b0;
      found_in     = 1'b0;
      victim_in    = '0;
      rsp_count_in = count_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop          = 1'b1;
               tgt_in       = tgt;
               is_victim_in = (head.cmd.op == OP_VICTIM);
               if (detach_go && !multi) begin
                  oldest_in      = '0;
                  newest_in      = '0;
                  member_in[tgt] = 1'b0;
                  count_in       = count_ff - COUNT_W'(1);
                  rsp_valid_in   = 1'b1;
                  found_in       = (head.cmd.op == OP_VICTIM);
                  victim_in      = (head.cmd.op == OP_VICTIM) ? tgt : '0;
                  rsp_count_in   = count_ff - COUNT_W'(1);
               end else if (detach_go) begin
                  // links of tgt come back from the memories next cycle
                  rsp_valid_in = 1'b0;
               end else if (append_go) begin
                  if (count_ff == '0) begin
                     oldest_in = tgt;
                  end else begin
                     next_we = 1'b1;
                     prev_we = 1'b1;
                  end
                  newest_in      = tgt;
                  member_in[tgt] = 1'b1;
                  count_in       = count_ff + COUNT_W'(1);
                  rsp_valid_in   = 1'b1;
                  rsp_count_in   = count_ff + COUNT_W'(1);
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         BK_DETACH: begin
            if (tgt_ff == oldest_ff) begin
               oldest_in = nx_rd_ff;
            end else if (tgt_ff == newest_ff) begin
               newest_in = pv_rd_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = pv_rd_ff;
               next_wdata = nx_rd_ff;
               prev_we    = 1'b1;
               prev_waddr = nx_rd_ff;
               prev_wdata = pv_rd_ff;
            end
            member_in[tgt_ff] = 1'b0;
            count_in          = count_ff - COUNT_W'(1);
            rsp_valid_in      = 1'b1;
            found_in          = is_victim_ff;
            victim_in         = is_victim_ff ? tgt_ff : '0;
            rsp_count_in      = count_ff - COUNT_W'(1);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         member_ff    <= '0;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         member_ff    <= member_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff       <= tgt_in;
      is_victim_ff <= is_victim_in;
      found_ff     <= found_in;
      victim_ff    <= victim_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      nx_rd_ff <= next_mem[tgt];
      pv_rd_ff <= prev_mem[tgt];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_victim_found    = found_ff;
   assign rsp_victim_frame    = victim_ff;
   assign rsp_candidate_count = rsp_count_ff;

endmodule

@@ rtl/core/lru_replacement_tracker_unit.sv @@
`timescale 1ns / 1ps
// path: an accepted item passes the front register, queue and response register; a frame
//   leaving a set of two or more frames also passes the detach state, fed by its links read
//   from the link memories. throughput: one item per cycle while not busy, none in the detach
//   state; a 2-entry queue absorbs this, busy while it and the front register are full
// reset: synchronous, clears membership flags, order pointers, count, queue and strobe;
//   link memories are not cleared. results cannot be stalled by the receiver
module lru_replacement_tracker_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lrt_pkg::ACTION_W-1:0]  req_action,
   input  logic [lrt_pkg::FRAME_W-1:0]   req_frame_number,
   output logic                          rsp_valid,
   output logic                          rsp_victim_found,
   output logic [lrt_pkg::FRAME_W-1:0]   rsp_victim_frame,
   output logic [lrt_pkg::COUNT_W-1:0]   rsp_candidate_count
);
   import lrt_pkg::*;

   cmd_slot_type push, head;
   logic         push_ready, pop;

   lrt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_frame_number (req_frame_number),
      .push             (push),
      .push_ready       (push_ready)
   );

   lrt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head)
   );

   lrt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_victim_found    (rsp_victim_found),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_candidate_count (rsp_candidate_count)
   );

endmodule

@@ rtl/core/lrt_checker.sv @@
`timescale 1ns / 1ps
module lrt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_victim_found,
   input logic [lrt_pkg::FRAME_W-1:0]   rsp_victim_frame,
   input logic [lrt_pkg::COUNT_W-1:0]   rsp_candidate_count
);
   import lrt_pkg::*;

   // pipeline is empty right after reset
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or result right after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_candidate_count <= COUNT_W'(NUM_FRAMES)))
      else $error("candidate count above frame total");

   a_no_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_victim_found) |-> (rsp_victim_frame == '0))
      else $error("victim frame set without a victim");

   a_victim_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_victim_found) |-> (rsp_candidate_count < COUNT_W'(NUM_FRAMES)))
      else $error("victim reported with a full set");

   // each item moves the count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && !$past(reset)) |->
         ((rsp_candidate_count == $past(rsp_candidate_count)) ||
          (rsp_candidate_count == $past(rsp_candidate_count) + COUNT_W'(1)) ||
          (rsp_candidate_count == $past(rsp_candidate_count) - COUNT_W'(1))))
      else $error("candidate count jumped by more than one");

endmodule

bind lru_replacement_tracker_unit lrt_checker u_checker (.*);

@@ dv/lru_tracker_checker.sv @@
`timescale 1ns / 1ps
module lru_tracker_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [lrt_pkg::ACTION_W-1:0] req_action,
   input  logic [lrt_pkg::FRAME_W-1:0]  req_frame_number,
   input  logic                         rsp_valid,
   input  logic                         rsp_victim_found,
   input  logic [lrt_pkg::FRAME_W-1:0]  rsp_victim_frame,
   input  logic [lrt_pkg::COUNT_W-1:0]  rsp_candidate_count,
   output int                           mismatch_count,
   output int                           pending_count
);
   import lrt_pkg::*;

   typedef struct {
      logic               found;
      logic [FRAME_W-1:0] frame;
      logic [COUNT_W-1:0] count;
   } lru_result_type;

   lru_result_type     expected_results[$];
   logic               in_set [NUM_FRAMES];
   logic [FRAME_W-1:0] link_next [NUM_FRAMES];
   logic [FRAME_W-1:0] link_prev [NUM_FRAMES];
   logic [FRAME_W-1:0] oldest;
   logic [FRAME_W-1:0] newest;
   logic [COUNT_W-1:0] set_size;
   int                 fail_total = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic void unlink_frame(input logic [FRAME_W-1:0] f);
      logic [FRAME_W-1:0] nx;
      logic [FRAME_W-1:0] pv;
      nx = link_next[f];
      pv = link_prev[f];
      if (set_size <= 1) begin
         oldest = '0;
         newest = '0;
      end else if (f == oldest) begin
         oldest = nx;
      end else if (f == newest) begin
         newest = pv;
      end else begin
         link_next[pv] = nx;
         link_prev[nx] = pv;
      end
      in_set[f] = 1'b0;
      if (set_size > 0) set_size = set_size - 1'b1;
   endfunction

   function automatic void link_at_newest(input logic [FRAME_W-1:0] f);
      if (set_size == 0) begin
         oldest = f;
      end else begin
         link_next[newest] = f;
         link_prev[f]      = newest;
      end
      newest    = f;
      in_set[f] = 1'b1;
      set_size  = set_size + 1'b1;
   endfunction

   function automatic lru_result_type apply_request(input logic [ACTION_W-1:0] act,
                                                    input logic [FRAME_W-1:0] frm);
      lru_result_type res;
      res.found = 1'b0;
      res.frame = '0;
      case (act)
         ACT_VICTIM: begin
            if (set_size > 0) begin
               res.found = 1'b1;
               res.frame = oldest;
               unlink_frame(oldest);
            end
         end
         ACT_PIN: begin
            if (in_set[frm]) unlink_frame(frm);
         end
         ACT_UNPIN: begin
            if (!in_set[frm]) link_at_newest(frm);
         end
         default: ;
      endcase
      res.count = set_size;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_total++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      lru_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            in_set[i]    = 1'b0;
            link_next[i] = '0;
            link_prev[i] = '0;
         end
         oldest   = '0;
         newest   = '0;
         set_size = '0;
         expected_results.delete();
      end else begin
         // results only come after their item is accepted, so check before queuing
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf(
                  "result with no item pending (found %0b frame %0d count %0d)",
                  rsp_victim_found, rsp_victim_frame, rsp_candidate_count));
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_victim_found !== want.found)
                  report_mismatch($sformatf("victim_found got %0b, expected %0b",
                                            rsp_victim_found, want.found));
               if (rsp_victim_frame !== want.frame)
                  report_mismatch($sformatf("victim_frame got %0d, expected %0d",
                                            rsp_victim_frame, want.frame));
               if (rsp_candidate_count !== want.count)
                  report_mismatch($sformatf("candidate_count got %0d, expected %0d",
                                            rsp_candidate_count, want.count));
            end
         end
         if (start && !busy)
            expected_results.insert(expected_results.size(),
                                    apply_request(req_action, req_frame_number));
      end
      mismatch_count <= fail_total;
      pending_count  <= expected_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import lrt_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1500;
   localparam int QUIET_TAIL  = 200;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic [ACTION_W-1:0] req_action       = '0;
   logic [FRAME_W-1:0]  req_frame_number = '0;
   logic                busy;
   logic                rsp_valid;
   logic                rsp_victim_found;
   logic [FRAME_W-1:0]  rsp_victim_frame;
   logic [COUNT_W-1:0]  rsp_candidate_count;
   int                  mismatch_count;
   int                  pending_count;

   int                  items_sent = 0;
   bit                  gaps_on    = 1'b1;
   logic [FRAME_W-1:0]  frame_order [NUM_FRAMES];

   always #1 clock = ~clock;

   lru_replacement_tracker_unit uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_frame_number    (req_frame_number),
      .rsp_valid           (rsp_valid),
      .rsp_victim_found    (rsp_victim_found),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_candidate_count (rsp_candidate_count)
   );

   lru_tracker_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_frame_number    (req_frame_number),
      .rsp_valid           (rsp_valid),
      .rsp_victim_found    (rsp_victim_found),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_candidate_count (rsp_candidate_count),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count)
   );

   task automatic issue_request(input logic [ACTION_W-1:0] act, input logic [FRAME_W-1:0] frm);
      int gap;
      if (gaps_on && items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         start            <= 1'b0;
         req_action       <= ACTION_W'($urandom);
         req_frame_number <= FRAME_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= act;
      req_frame_number <= frm;
      do @(posedge clock); while (busy);
      if (act != ACT_UNUSED) items_sent++;
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic void shuffle_frames();
      logic [FRAME_W-1:0] t;
      int                 j;
      for (int i = 0; i < NUM_FRAMES; i++) frame_order[i] = FRAME_W'(i);
      for (int i = NUM_FRAMES - 1; i > 0; i--) begin
         j              = $urandom_range(0, i);
         t              = frame_order[i];
         frame_order[i] = frame_order[j];
         frame_order[j] = t;
      end
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(input int w_unpin, input int w_pin);
      int r;
      r = $urandom_range(0, 99);
      if (r < w_unpin) return ACT_UNPIN;
      if (r < w_unpin + w_pin) return ACT_PIN;
      return ACT_VICTIM;
   endfunction

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int                 kind;
      int                 n;
      int                 base;
      logic [FRAME_W-1:0] frm;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty set, absent pin, unused code, removal at each end and in the middle
      issue_request(ACT_VICTIM, 6'd0);
      issue_request(ACT_PIN, 6'd7);
      issue_request(ACT_UNUSED, 6'd63);
      issue_request(ACT_UNPIN, 6'd0);
      issue_request(ACT_UNPIN, 6'd63);
      issue_request(ACT_UNPIN, 6'd0);
      issue_request(ACT_UNPIN, 6'd5);
      issue_request(ACT_UNPIN, 6'd10);
      issue_request(ACT_PIN, 6'd63);
      issue_request(ACT_PIN, 6'd0);
      issue_request(ACT_PIN, 6'd10);
      issue_request(ACT_VICTIM, 6'd63);
      issue_request(ACT_VICTIM, 6'd0);
      issue_request(ACT_UNPIN, 6'd42);
      issue_request(ACT_PIN, 6'd42);
      issue_request(ACT_UNPIN, 6'd1);
      issue_request(ACT_UNPIN, 6'd2);
      issue_request(ACT_UNPIN, 6'd3);
      issue_request(ACT_UNUSED, 6'd2);
      issue_request(ACT_VICTIM, 6'd21);
      issue_request(ACT_PIN, 6'd3);
      issue_request(ACT_VICTIM, 6'd0);
      issue_request(ACT_VICTIM, 6'd0);
      drain_pending();

      items_sent = 0;
      while (items_sent < ITEM_TARGET) begin
         gaps_on = ($urandom_range(0, 2) != 0);
         kind    = $urandom_range(0, 9);
         case (kind)
            0, 1: begin
               // fill with distinct frames, often the whole set
               shuffle_frames();
               n = ($urandom_range(0, 1) != 0) ? NUM_FRAMES : $urandom_range(8, NUM_FRAMES);
               for (int i = 0; i < n; i++) issue_request(ACT_UNPIN, frame_order[i]);
            end
            2, 3: begin
               n = $urandom_range(4, 70);
               for (int i = 0; i < n; i++)
                  issue_request(pick_action(5, 15), FRAME_W'($urandom));
            end
            4, 5, 6, 7: begin
               // narrow window of frames so pins and repeated unpins hit members
               n    = $urandom_range(20, 60);
               base = $urandom_range(0, NUM_FRAMES - 8);
               for (int i = 0; i < n; i++) begin
                  frm = FRAME_W'(base + $urandom_range(0, 7));
                  issue_request(pick_action(40, 30), frm);
               end
            end
            8: begin
               n = $urandom_range(3, 10);
               for (int i = 0; i < n; i++)
                  issue_request(ACTION_W'($urandom), FRAME_W'($urandom));
            end
            default: begin
               // no pauses in the closing stretch
               if (items_sent < ITEM_TARGET - QUIET_TAIL) drain_pending();
               n = $urandom_range(5, 20);
               for (int i = 0; i < n; i++)
                  issue_request(pick_action(34, 33), FRAME_W'($urandom));
            end
         endcase
      end

      drain_pending();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/lrt_pkg.sv
rtl/core/lrt_front.sv
rtl/core/lrt_queue.sv
rtl/core/lrt_back.sv
rtl/core/lru_replacement_tracker_unit.sv
rtl/core/lrt_checker.sv
dv/lru_tracker_checker.sv
dv/tb_top.sv
